// File: src/ndr_pkg.sv
// ----------------------------------------------------------------------------
// ndr_pkg
// Shared types and constants of the NTFS data run decoder.
// ----------------------------------------------------------------------------
package ndr_pkg;

  localparam int unsigned MaxFieldBytes = 8;
  localparam int unsigned ByteW         = 8;
  localparam int unsigned WordW         = 64;
  localparam int unsigned WordBytes     = WordW / ByteW;
  localparam int unsigned SizeW         = 4;
  localparam int unsigned PosW          = 3;

  typedef struct packed {
    logic [WordW-1:0] run_length;
    logic [WordW-1:0] start_cluster;
    logic             is_sparse;
    logic             list_end;
    logic             header_error;
  } result_t;

endpackage

// File: src/ndr_in_if.sv
// ----------------------------------------------------------------------------
// ndr_in_if
// Runlist byte channel: valid/ready handshake with one byte per transaction.
// ----------------------------------------------------------------------------
interface ndr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       list_start;

  modport source (output valid, output data_byte, output list_start, input ready);
  modport sink   (input valid, input data_byte, input list_start, output ready);
endinterface

// File: src/ndr_out_if.sv
// ----------------------------------------------------------------------------
// ndr_out_if
// Decoded run channel: valid/ready handshake with one run per transaction.
// ----------------------------------------------------------------------------
interface ndr_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] run_length;
  logic [63:0] start_cluster;
  logic        is_sparse;
  logic        list_end;
  logic        header_error;

  modport source (output valid, output run_length, output start_cluster,
                  output is_sparse, output list_end, output header_error,
                  input ready);
  modport sink   (input valid, input run_length, input start_cluster,
                  input is_sparse, input list_end, input header_error,
                  output ready);
endinterface

// File: src/ntfs_data_run_decoder.sv
// ----------------------------------------------------------------------------
// ntfs_data_run_decoder
// NTFS runlist decoder: one runlist byte per transaction in, one decoded run
// (length, start cluster, sparse, end-of-list, header error) per finished run
// out.
// ----------------------------------------------------------------------------
// Takes one byte per clock cycle sustained. A byte is held in an input
// register, decoded combinationally against the parse state (the 64-bit add
// of the sign-extended offset to the running cluster sets the cycle time) and
// the run is registered in the output buffer. A skid entry behind the
// output register keeps input flowing while a run waits; input stalls only
// once both entries hold runs not yet taken.
module ntfs_data_run_decoder (
  input logic        clk_i,
  input logic        rst_ni,
  ndr_in_if.sink     in_i,
  ndr_out_if.source  out_o
);

  logic                        in_valid_q;
  logic [ndr_pkg::ByteW-1:0]   byte_q;
  logic                        start_q;
  logic                        buf_full;
  logic                        advance;
  logic                        accept;
  logic                        res_valid;
  ndr_pkg::result_t            res;
  ndr_pkg::result_t            out_data;

  assign in_i.ready = !in_valid_q || !buf_full;
  assign accept     = in_i.valid && in_i.ready;
  assign advance    = in_valid_q && !buf_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q  <= in_i.data_byte;
      start_q <= in_i.list_start;
    end
  end

  ndr_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (advance),
    .data_byte_i  (byte_q),
    .list_start_i (start_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  ndr_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (buf_full),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_data)
  );

  assign out_o.run_length    = out_data.run_length;
  assign out_o.start_cluster = out_data.start_cluster;
  assign out_o.is_sparse     = out_data.is_sparse;
  assign out_o.list_end      = out_data.list_end;
  assign out_o.header_error  = out_data.header_error;

endmodule

// File: src/ndr_parser.sv
// ----------------------------------------------------------------------------
// ndr_parser
// Runlist parse state: header decode, little-endian field assembly and the
// running cluster number. One byte is consumed per enabled cycle.
// ----------------------------------------------------------------------------
module ndr_parser (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic [ndr_pkg::ByteW-1:0] data_byte_i,
  input  logic                    list_start_i,
  output logic                    res_valid_o,
  output ndr_pkg::result_t        res_o
);

  typedef enum logic [1:0] {
    PhHeader,
    PhLength,
    PhOffset,
    PhHalt
  } phase_e;

  phase_e                         phase_q, phase_d, phase_cur;
  logic [ndr_pkg::SizeW-1:0]      len_left_q, len_left_d, len_left_dec;
  logic [ndr_pkg::SizeW-1:0]      off_left_q, off_left_d, off_left_dec;
  logic [ndr_pkg::PosW-1:0]       pos_q, pos_d;
  logic [ndr_pkg::WordW-1:0]      len_acc_q, len_acc_d, len_acc_new;
  logic [ndr_pkg::WordW-1:0]      off_acc_q, off_acc_d, off_ext;
  logic [ndr_pkg::WordW-1:0]      run_q, run_d, run_cur;
  logic [ndr_pkg::SizeW-1:0]      lsz, osz;
  logic                           res_valid;
  ndr_pkg::result_t               res;

  assign phase_cur    = list_start_i ? PhHeader : phase_q;
  assign run_cur      = list_start_i ? '0 : run_q;
  assign lsz          = data_byte_i[ndr_pkg::SizeW-1:0];
  assign osz          = data_byte_i[ndr_pkg::ByteW-1:ndr_pkg::SizeW];
  assign len_left_dec = len_left_q - ndr_pkg::SizeW'(1);
  assign off_left_dec = off_left_q - ndr_pkg::SizeW'(1);

  always_comb begin
    len_acc_new = len_acc_q;
    len_acc_new[pos_q*ndr_pkg::ByteW +: ndr_pkg::ByteW] = data_byte_i;
  end

  // Place the top offset byte and sign-fill every byte above it.
  always_comb begin
    off_ext = off_acc_q;
    for (int k = 0; k < ndr_pkg::WordBytes; k++) begin
      if (ndr_pkg::PosW'(k) == pos_q) begin
        off_ext[k*ndr_pkg::ByteW +: ndr_pkg::ByteW] = data_byte_i;
      end else if (ndr_pkg::PosW'(k) > pos_q) begin
        off_ext[k*ndr_pkg::ByteW +: ndr_pkg::ByteW] = {ndr_pkg::ByteW{data_byte_i[7]}};
      end
    end
  end

  always_comb begin
    phase_d    = phase_cur;
    len_left_d = len_left_q;
    off_left_d = off_left_q;
    pos_d      = pos_q;
    len_acc_d  = len_acc_q;
    off_acc_d  = off_acc_q;
    run_d      = run_cur;
    res_valid  = 1'b0;
    res        = '{run_length: '0, start_cluster: run_cur, is_sparse: 1'b0,
                   list_end: 1'b0, header_error: 1'b0};
    case (phase_cur)
      PhHeader: begin
        if (data_byte_i == '0) begin
          phase_d      = PhHalt;
          res_valid    = 1'b1;
          res.list_end = 1'b1;
        end else if (lsz == '0 || 32'(lsz) > ndr_pkg::MaxFieldBytes ||
                     32'(osz) > ndr_pkg::MaxFieldBytes) begin
          phase_d          = PhHalt;
          res_valid        = 1'b1;
          res.header_error = 1'b1;
        end else begin
          phase_d    = PhLength;
          len_left_d = lsz;
          off_left_d = osz;
          pos_d      = '0;
          len_acc_d  = '0;
          off_acc_d  = '0;
        end
      end
      PhLength: begin
        len_acc_d  = len_acc_new;
        len_left_d = len_left_dec;
        pos_d      = pos_q + ndr_pkg::PosW'(1);
        if (len_left_dec == '0) begin
          pos_d = '0;
          if (off_left_q == '0) begin
            phase_d        = PhHeader;
            res_valid      = 1'b1;
            res.run_length = len_acc_new;
            res.is_sparse  = 1'b1;
          end else begin
            phase_d = PhOffset;
          end
        end
      end
      PhOffset: begin
        off_acc_d  = off_ext;
        off_left_d = off_left_dec;
        pos_d      = pos_q + ndr_pkg::PosW'(1);
        if (off_left_dec == '0) begin
          pos_d             = '0;
          run_d             = run_cur + off_ext;
          phase_d           = PhHeader;
          res_valid         = 1'b1;
          res.run_length    = len_acc_q;
          res.start_cluster = run_cur + off_ext;
        end
      end
      default: begin
        phase_d = PhHalt;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhHeader;
      len_left_q <= '0;
      off_left_q <= '0;
      pos_q      <= '0;
      len_acc_q  <= '0;
      off_acc_q  <= '0;
      run_q      <= '0;
    end else if (en_i) begin
      phase_q    <= phase_d;
      len_left_q <= len_left_d;
      off_left_q <= off_left_d;
      pos_q      <= pos_d;
      len_acc_q  <= len_acc_d;
      off_acc_q  <= off_acc_d;
      run_q      <= run_d;
    end
  end

  assign res_valid_o = en_i & res_valid;
  assign res_o       = res;

endmodule

// File: src/ndr_out_buf.sv
// ----------------------------------------------------------------------------
// ndr_out_buf
// Two-entry result buffer: output register plus skid entry, in order.
// ----------------------------------------------------------------------------
module ndr_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ndr_pkg::result_t push_data_i,
  output logic             full_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ndr_pkg::result_t out_data_o
);

  logic             out_valid_q, skid_valid_q;
  ndr_pkg::result_t out_q, skid_q;
  logic             pop;

  assign pop = out_valid_q & out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (out_valid_q && !pop) begin
      skid_valid_q <= push_i;
    end else begin
      out_valid_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (out_valid_q && !pop) begin
      if (push_i) begin
        skid_q <= push_data_i;
      end
    end else if (push_i) begin
      out_q <= push_data_i;
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
